// File: rtl/core/symp_pkg.sv
`default_nettype none
package symp_pkg;

    localparam int MAX_PATCH_EDGE_DEF  = 64;
    localparam int MAX_FILTER_EDGE_DEF = 32;

    localparam int PIX_W  = 8;
    localparam int EDGE_W = 7;
    localparam int FILT_W = 6;
    localparam int POS_W  = 7;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_PATCH_EDGE  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FILTER_EDGE = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    localparam logic [EDGE_W-1:0] PATCH_EDGE_RST  = 7'd64;
    localparam logic [FILT_W-1:0] FILTER_EDGE_RST = 6'd0;

    typedef struct packed {
        logic capture;
        logic load;
        logic mirror;
        logic addr;
        logic read;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/core/symp_ram.sv
`default_nettype none
module symp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/core/symp_ctrl.sv
`default_nettype none
module symp_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_kind,
    output symp_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MIRROR,
        S_ADDR,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy  <= 1'b1;
                        r_state <= (i_kind == symp_pkg::KIND_EMIT) ? S_MIRROR : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_MIRROR: r_state <= S_ADDR;
                S_ADDR:   r_state <= S_READ;
                S_READ: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && accept;
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.mirror  = (r_state == S_MIRROR);
        o_cmd.addr    = (r_state == S_ADDR);
        o_cmd.read    = (r_state == S_READ);
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// File: rtl/core/symp_dp.sv
`default_nettype none
module symp_dp #(
    parameter int MAX_PATCH_EDGE  = symp_pkg::MAX_PATCH_EDGE_DEF,
    parameter int MAX_FILTER_EDGE = symp_pkg::MAX_FILTER_EDGE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [symp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [symp_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire symp_pkg::t_cmd               i_cmd,
    input  wire logic [symp_pkg::PIX_W-1:0]   i_pixel_in,
    output logic      [symp_pkg::PIX_W-1:0]   o_pixel_out,
    output logic      [symp_pkg::POS_W-1:0]   o_out_row,
    output logic      [symp_pkg::POS_W-1:0]   o_out_col,
    output logic                              o_last_of_patch
);

    localparam int DEPTH = MAX_PATCH_EDGE * MAX_PATCH_EDGE;
    localparam int NW    = $clog2(MAX_PATCH_EDGE + 1);
    localparam int OW    = (MAX_PATCH_EDGE > 1) ? $clog2(MAX_PATCH_EDGE) : 1;
    localparam int FW    = (MAX_FILTER_EDGE > 0) ? $clog2(MAX_FILTER_EDGE + 1) : 1;
    localparam int CW    = $clog2(MAX_PATCH_EDGE + MAX_FILTER_EDGE + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);

    logic [symp_pkg::EDGE_W-1:0] r_cfg_edge;
    logic [symp_pkg::FILT_W-1:0] r_cfg_filter;
    logic [LW-1:0]               r_nn;
    logic [LW-1:0]               r_load_count;
    logic [CW-1:0]               r_emit_row;
    logic [CW-1:0]               r_emit_col;
    logic [symp_pkg::PIX_W-1:0]  r_pix_in;
    logic [OW-1:0]               r_mr;
    logic [OW-1:0]               r_mc;
    logic [AW-1:0]               r_addr;
    logic [CW-1:0]               r_out_row;
    logic [CW-1:0]               r_out_col;
    logic                        r_last;

    logic [NW-1:0] n_eff;
    logic [FW-1:0] f_eff;
    logic [CW-1:0] lead;
    logic [CW-1:0] padded;
    logic [CW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic          cur_last;
    logic          ram_we;

    function automatic logic [OW-1:0] mirror(input logic [CW-1:0] p,
                                             input logic [NW-1:0] n,
                                             input logic [CW-1:0] ld);
        logic [CW:0] pe;
        logic [CW:0] lde;
        logic [CW:0] ne;
        logic [CW:0] lim;
        logic [CW:0] t;
        pe  = {1'b0, p};
        lde = {1'b0, ld};
        ne  = (CW + 1)'(n);
        lim = ne - 1'b1;
        if (pe < lde) begin
            t = lde - 1'b1 - pe;
            if (t > lim) begin
                t = lim;
            end
        end else if (pe < lde + ne) begin
            t = pe - lde;
        end else begin
            t = pe - lde - ne;
            t = (t > lim) ? '0 : lim - t;
        end
        return OW'(t);
    endfunction

    always_comb begin
        if (r_cfg_edge == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_cfg_edge) > MAX_PATCH_EDGE) begin
            n_eff = NW'(MAX_PATCH_EDGE);
        end else begin
            n_eff = NW'(r_cfg_edge);
        end
        if (int'(r_cfg_filter) > MAX_FILTER_EDGE) begin
            f_eff = FW'(MAX_FILTER_EDGE);
        end else begin
            f_eff = FW'(r_cfg_filter);
        end
        lead   = CW'(f_eff >> 1);
        padded = CW'(n_eff) + CW'(f_eff);
        if (r_emit_row >= padded || r_emit_col >= padded) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            cur_row = r_emit_row;
            cur_col = r_emit_col;
        end
        cur_last = (cur_row == padded - 1'b1) && (cur_col == padded - 1'b1);
    end

    assign ram_we = i_cmd.load && (r_load_count < r_nn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_edge   <= symp_pkg::PATCH_EDGE_RST;
            r_cfg_filter <= symp_pkg::FILTER_EDGE_RST;
            r_nn         <= '0;
            r_load_count <= '0;
            r_emit_row   <= '0;
            r_emit_col   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    symp_pkg::REG_PATCH_EDGE:  r_cfg_edge   <= i_cfg_data;
                    symp_pkg::REG_FILTER_EDGE: r_cfg_filter <= symp_pkg::FILT_W'(i_cfg_data);
                    default: ;
                endcase
            end
            r_nn <= LW'(n_eff) * LW'(n_eff);
            if (ram_we) begin
                r_load_count <= r_load_count + 1'b1;
            end
            if (i_cmd.mirror) begin
                if (cur_last) begin
                    r_emit_row   <= '0;
                    r_emit_col   <= '0;
                    r_load_count <= '0;
                end else if (cur_col + 1'b1 >= padded) begin
                    r_emit_col <= '0;
                    r_emit_row <= cur_row + 1'b1;
                end else begin
                    r_emit_row <= cur_row;
                    r_emit_col <= cur_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix_in <= i_pixel_in;
        end
        if (i_cmd.mirror) begin
            r_mr      <= mirror(cur_row, n_eff, lead);
            r_mc      <= mirror(cur_col, n_eff, lead);
            r_out_row <= cur_row;
            r_out_col <= cur_col;
            r_last    <= cur_last;
        end
        if (i_cmd.addr) begin
            r_addr <= AW'(r_mr * n_eff + (OW + NW)'(r_mc));
        end
    end

    symp_ram #(
        .WIDTH (symp_pkg::PIX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_load_count)),
        .i_wdata (r_pix_in),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (o_pixel_out)
    );

    assign o_out_row       = symp_pkg::POS_W'(r_out_row);
    assign o_out_col       = symp_pkg::POS_W'(r_out_col);
    assign o_last_of_patch = r_last;

endmodule
`default_nettype wire

// File: rtl/core/symmetric_pad_patch_top.sv
// Load beat: start captures the pixel, LOAD writes it, then idle; no result.
// Emit beat: start, then MIRROR, ADDR, READ, OUT with the result strobe, then idle.
// Emit rate is set by the controller sequence: mirror, address multiply, store read, output.
// Receiver cannot stall: each result is shown for one cycle with o_valid.
// Synchronous active-low reset clears counters, config and controller; pipeline
// registers and pixel store are not cleared; the store is invalid until loaded.
`default_nettype none
module symmetric_pad_patch_top #(
    parameter int MAX_PATCH_EDGE  = symp_pkg::MAX_PATCH_EDGE_DEF,
    parameter int MAX_FILTER_EDGE = symp_pkg::MAX_FILTER_EDGE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [symp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [symp_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_kind,
    input  wire logic [symp_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                              o_valid,
    output logic      [symp_pkg::PIX_W-1:0]   o_pixel_out,
    output logic      [symp_pkg::POS_W-1:0]   o_out_row,
    output logic      [symp_pkg::POS_W-1:0]   o_out_col,
    output logic                              o_last_of_patch
);

    symp_pkg::t_cmd cmd;

    symp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    symp_dp #(
        .MAX_PATCH_EDGE  (MAX_PATCH_EDGE),
        .MAX_FILTER_EDGE (MAX_FILTER_EDGE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_pixel_in      (i_pixel_in),
        .o_pixel_out     (o_pixel_out),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_patch (o_last_of_patch)
    );

endmodule
`default_nettype wire

// File: rtl/core/symp_checker.sv
`default_nettype none
module symp_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_start,
    input wire logic                       i_kind,
    input wire logic                       o_busy,
    input wire logic                       o_valid,
    input wire logic [symp_pkg::POS_W-1:0] o_out_row,
    input wire logic [symp_pkg::POS_W-1:0] o_out_col,
    input wire logic                       o_last_of_patch
);

    a_emit_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == symp_pkg::KIND_EMIT) |-> ##4 o_valid)
        else $error("emit beat without result after four cycles");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while idle");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_patch) |-> (o_out_row == o_out_col))
        else $error("last pixel off the corner");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_busy && !o_valid))
        else $error("outputs active after reset");

endmodule

bind symmetric_pad_patch_top symp_checker u_symp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .i_kind          (i_kind),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_out_row       (o_out_row),
    .o_out_col       (o_out_col),
    .o_last_of_patch (o_last_of_patch)
);
`default_nettype wire
